// File: src/space_time_region_classifier_assert.svh
// Assertion macros shared by the checker.
`ifndef SPACE_TIME_REGION_CLASSIFIER_ASSERT_SVH
`define SPACE_TIME_REGION_CLASSIFIER_ASSERT_SVH
// Implication checked on every edge out of reset.
`define STRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label failed");
// Next-cycle implication.
`define STRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label failed");
`endif

// File: src/strc_pkg.sv
package strc_pkg;
  localparam int unsigned TbSlots    = 16;
  localparam int unsigned BoxSlots   = 16;
  localparam int unsigned CombSlots  = 16;
  localparam int unsigned NumDomains = 8;
  localparam int unsigned NumAreas   = 8;
  localparam int unsigned NumMatrix  = 16;
  localparam int unsigned TbIdxW     = $clog2(TbSlots + 1);
  localparam int unsigned BoxIdxW    = $clog2(BoxSlots + 1);
  localparam int unsigned CombIdxW   = $clog2(CombSlots + 1);
  localparam logic signed [3:0] RefNone = 4'sb1111;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_TIME  = 2'd1,
    KIND_BOX   = 2'd2,
    KIND_COMB  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_BOX,
    S_COMB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [3:0] area_ref;
    logic signed [3:0] time_ref;
    logic [3:0]        matrix_ref;
    logic [47:0]       time_a;
    logic [47:0]       time_b;
    logic signed [31:0] x_a;
    logic signed [31:0] y_a;
    logic signed [31:0] z_a;
    logic signed [31:0] x_b;
    logic signed [31:0] y_b;
    logic signed [31:0] z_b;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [3:0]        matrix_index;
    logic signed [3:0] domain_found;
    logic signed [3:0] area_found;
  } result_t;
endpackage

// File: src/strc_if.sv
interface strc_in_if;
  logic             valid;
  logic             ready;
  strc_pkg::item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface strc_out_if;
  logic              valid;
  logic              ready;
  strc_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/strc_cmp.sv
// Shared compare unit: one lane of lo <= v <= hi (or v < hi) per cycle.
module strc_cmp (
  input  logic [47:0] v_i,
  input  logic [47:0] lo_i,
  input  logic [47:0] hi_i,
  input  logic        hi_excl_i,
  output logic        hit_o
);
  logic ge_lo;
  logic le_hi;
  assign ge_lo = (v_i >= lo_i);
  assign le_hi = hi_excl_i ? (v_i < hi_i) : (v_i <= hi_i);
  assign hit_o = ge_lo && le_hi;
endmodule

// File: src/space_time_region_classifier.sv
// Appends and rejects resolve in S_TIME, then wait in S_DONE until the result is taken.
// Queries walk the filled entries of the time table, then each box axis by axis,
// then the combination table; the combination walk stops at the first match.
// A new item is accepted only back in S_IDLE; the result must be taken first.
// Reset: asynchronous active low; clears table counts, default_matrix and
// control. Table contents are undefined until written.
module space_time_region_classifier (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  strc_in_if.sink              in_i,
  strc_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i
);
  localparam int unsigned TbW   = $clog2(strc_pkg::TbSlots);
  localparam int unsigned BoxW  = $clog2(strc_pkg::BoxSlots);
  localparam int unsigned CombW = $clog2(strc_pkg::CombSlots);

  logic [47:0] tb_lo_m [strc_pkg::TbSlots];
  logic [47:0] tb_hi_m [strc_pkg::TbSlots];
  logic [2:0]  tb_dom_m [strc_pkg::TbSlots];
  logic [31:0] bx_lo_m [strc_pkg::BoxSlots][3];
  logic [31:0] bx_hi_m [strc_pkg::BoxSlots][3];
  logic [2:0]  bx_ty_m [strc_pkg::BoxSlots];
  logic [3:0]  cb_ar_m [strc_pkg::CombSlots];
  logic [3:0]  cb_tm_m [strc_pkg::CombSlots];
  logic [3:0]  cb_mx_m [strc_pkg::CombSlots];

  logic [strc_pkg::TbIdxW-1:0]   tb_cnt_q, tb_cnt_d;
  logic [strc_pkg::BoxIdxW-1:0]  bx_cnt_q, bx_cnt_d;
  logic [strc_pkg::CombIdxW-1:0] cb_cnt_q, cb_cnt_d;
  logic [3:0] dflt_q;
  strc_pkg::state_e state_q, state_d;
  strc_pkg::item_t  item_q;
  logic [7:0]  idx_q, idx_d;
  logic [1:0]  ax_q, ax_d;
  logic        bx_ok_q, bx_ok_d;
  logic signed [3:0] dom_q, dom_d, area_q, area_d;
  logic [3:0]  mat_q, mat_d;
  logic [1:0]  st_q, st_d;
  logic        wr_tb, wr_bx, wr_cb;

  // Biased coordinates make unsigned order equal signed order.
  logic [31:0] qv, lo32, hi32;
  logic [47:0] cv, clo, chi;
  logic        hi_excl, hit;
  logic [31:0] qpos [3];

  assign qpos[0] = item_q.x_a ^ 32'h8000_0000;
  assign qpos[1] = item_q.y_a ^ 32'h8000_0000;
  assign qpos[2] = item_q.z_a ^ 32'h8000_0000;

  always_comb begin
    qv   = qpos[ax_q];
    lo32 = bx_lo_m[idx_q[BoxW-1:0]][ax_q];
    hi32 = bx_hi_m[idx_q[BoxW-1:0]][ax_q];
    if (state_q == strc_pkg::S_TIME) begin
      cv = item_q.time_a; clo = tb_lo_m[idx_q[TbW-1:0]]; chi = tb_hi_m[idx_q[TbW-1:0]];
      hi_excl = 1'b1;
    end else begin
      cv = {16'd0, qv}; clo = {16'd0, lo32}; chi = {16'd0, hi32};
      hi_excl = 1'b0;
    end
  end

  strc_cmp u_cmp (
    .v_i(cv), .lo_i(clo), .hi_i(chi), .hi_excl_i(hi_excl), .hit_o(hit)
  );

  logic tref_bad, aref_bad, comb_bad;
  always_comb begin
    tref_bad = item_q.time_ref < 0 ||
               item_q.time_ref >= $signed(5'(strc_pkg::NumDomains));
    aref_bad = item_q.area_ref < 0 ||
               item_q.area_ref >= $signed(5'(strc_pkg::NumAreas));
    comb_bad = (item_q.area_ref == strc_pkg::RefNone &&
                item_q.time_ref == strc_pkg::RefNone) ||
               item_q.area_ref < -1 || item_q.time_ref < -1 ||
               item_q.area_ref >= $signed(5'(strc_pkg::NumAreas)) ||
               item_q.time_ref >= $signed(5'(strc_pkg::NumDomains)) ||
               {1'b0, item_q.matrix_ref} >= 5'(strc_pkg::NumMatrix);
  end

  always_comb begin
    state_d = state_q; idx_d = idx_q; ax_d = ax_q; bx_ok_d = bx_ok_q;
    dom_d = dom_q; area_d = area_q; mat_d = mat_q; st_d = st_q;
    tb_cnt_d = tb_cnt_q; bx_cnt_d = bx_cnt_q; cb_cnt_d = cb_cnt_q;
    wr_tb = 1'b0; wr_bx = 1'b0; wr_cb = 1'b0;
    in_i.ready = 1'b0;
    case (state_q)
      strc_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = strc_pkg::S_TIME; idx_d = '0; ax_d = '0; bx_ok_d = 1'b1;
          dom_d = strc_pkg::RefNone; area_d = strc_pkg::RefNone;
          mat_d = '0; st_d = strc_pkg::ST_OK;
        end
      end
      strc_pkg::S_TIME: begin
        // Appends resolve here; queries walk the time table.
        case (strc_pkg::kind_e'(item_q.kind))
          strc_pkg::KIND_TIME: begin
            state_d = strc_pkg::S_DONE;
            if (tref_bad) st_d = strc_pkg::ST_INVALID;
            else if (tb_cnt_q >= strc_pkg::TbIdxW'(strc_pkg::TbSlots))
              st_d = strc_pkg::ST_FULL;
            else begin wr_tb = 1'b1; tb_cnt_d = tb_cnt_q + 1'b1; end
          end
          strc_pkg::KIND_BOX: begin
            state_d = strc_pkg::S_DONE;
            if (aref_bad) st_d = strc_pkg::ST_INVALID;
            else if (bx_cnt_q >= strc_pkg::BoxIdxW'(strc_pkg::BoxSlots))
              st_d = strc_pkg::ST_FULL;
            else begin wr_bx = 1'b1; bx_cnt_d = bx_cnt_q + 1'b1; end
          end
          strc_pkg::KIND_COMB: begin
            state_d = strc_pkg::S_DONE;
            if (comb_bad) st_d = strc_pkg::ST_INVALID;
            else if (cb_cnt_q >= strc_pkg::CombIdxW'(strc_pkg::CombSlots))
              st_d = strc_pkg::ST_FULL;
            else begin wr_cb = 1'b1; cb_cnt_d = cb_cnt_q + 1'b1; end
          end
          default: begin
            if (8'(tb_cnt_q) == idx_q) begin
              state_d = strc_pkg::S_BOX; idx_d = '0;
            end else begin
              if (hit && (dom_q < 0 ||
                  $signed({1'b0, tb_dom_m[idx_q[TbW-1:0]]}) < dom_q))
                dom_d = $signed({1'b0, tb_dom_m[idx_q[TbW-1:0]]});
              idx_d = idx_q + 1'b1;
            end
          end
        endcase
      end
      strc_pkg::S_BOX: begin
        if (8'(bx_cnt_q) == idx_q) begin
          state_d = strc_pkg::S_COMB; idx_d = '0; mat_d = dflt_q;
        end else if (ax_q == 2'd2) begin
          if (bx_ok_q && hit && (area_q < 0 ||
              $signed({1'b0, bx_ty_m[idx_q[BoxW-1:0]]}) < area_q))
            area_d = $signed({1'b0, bx_ty_m[idx_q[BoxW-1:0]]});
          ax_d = '0; bx_ok_d = 1'b1; idx_d = idx_q + 1'b1;
        end else begin
          bx_ok_d = bx_ok_q && hit; ax_d = ax_q + 1'b1;
        end
      end
      strc_pkg::S_COMB: begin
        if (8'(cb_cnt_q) == idx_q) begin
          state_d = strc_pkg::S_DONE;
        end else if (cb_tm_m[idx_q[CombW-1:0]] == dom_q &&
                     cb_ar_m[idx_q[CombW-1:0]] == area_q) begin
          mat_d = cb_mx_m[idx_q[CombW-1:0]]; state_d = strc_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      strc_pkg::S_DONE: begin
        if (out_o.ready) state_d = strc_pkg::S_IDLE;
      end
      default: state_d = strc_pkg::S_IDLE;
    endcase
  end

  assign out_o.valid = (state_q == strc_pkg::S_DONE);
  assign out_o.payload.status       = st_q;
  assign out_o.payload.matrix_index = mat_q;
  assign out_o.payload.domain_found = dom_q;
  assign out_o.payload.area_found   = area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= strc_pkg::S_IDLE;
      tb_cnt_q <= '0;
      bx_cnt_q <= '0;
      cb_cnt_q <= '0;
      dflt_q   <= '0;
    end else begin
      state_q  <= state_d;
      tb_cnt_q <= tb_cnt_d;
      bx_cnt_q <= bx_cnt_d;
      cb_cnt_q <= cb_cnt_d;
      if (cfg_we_i) dflt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.payload;
    idx_q <= idx_d; ax_q <= ax_d; bx_ok_q <= bx_ok_d;
    dom_q <= dom_d; area_q <= area_d; mat_q <= mat_d; st_q <= st_d;
  end

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (wr_tb) begin
      tb_lo_m[tb_cnt_q[TbW-1:0]]  <= item_q.time_a;
      tb_hi_m[tb_cnt_q[TbW-1:0]]  <= item_q.time_b;
      tb_dom_m[tb_cnt_q[TbW-1:0]] <= item_q.time_ref[2:0];
    end
    if (wr_bx) begin
      bx_lo_m[bx_cnt_q[BoxW-1:0]][0] <= item_q.x_a ^ 32'h8000_0000;
      bx_lo_m[bx_cnt_q[BoxW-1:0]][1] <= item_q.y_a ^ 32'h8000_0000;
      bx_lo_m[bx_cnt_q[BoxW-1:0]][2] <= item_q.z_a ^ 32'h8000_0000;
      bx_hi_m[bx_cnt_q[BoxW-1:0]][0] <= item_q.x_b ^ 32'h8000_0000;
      bx_hi_m[bx_cnt_q[BoxW-1:0]][1] <= item_q.y_b ^ 32'h8000_0000;
      bx_hi_m[bx_cnt_q[BoxW-1:0]][2] <= item_q.z_b ^ 32'h8000_0000;
      bx_ty_m[bx_cnt_q[BoxW-1:0]]    <= item_q.area_ref[2:0];
    end
    if (wr_cb) begin
      cb_ar_m[cb_cnt_q[CombW-1:0]] <= item_q.area_ref;
      cb_tm_m[cb_cnt_q[CombW-1:0]] <= item_q.time_ref;
      cb_mx_m[cb_cnt_q[CombW-1:0]] <= item_q.matrix_ref;
    end
  end
endmodule

// File: src/strc_checker.sv
`include "space_time_region_classifier_assert.svh"
module strc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input strc_pkg::result_t out_payload
);
  `STRC_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid, out_payload.status != 2'd3)
  `STRC_ASSERT_IMP(a_no_take_while_busy, clk_i, rst_ni, out_valid, !in_ready)
  `STRC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `STRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
    out_valid && $stable(out_payload))
endmodule

bind space_time_region_classifier strc_checker u_strc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_payload(out_o.payload)
);
